FILE: hdl/session_table_with_aging_top_assert.svh
// assertion macros for the session table
`ifndef SESSION_TABLE_WITH_AGING_TOP_ASSERT_SVH
`define SESSION_TABLE_WITH_AGING_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define STA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define STA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/sta_pkg.sv
`default_nettype none

package sta_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // field widths
  localparam int KEY_W = 50;
  localparam int TICK_W = 32;
  localparam int TIMEOUT_W = 16;
  localparam int BL_COUNT_W = 3;
  localparam int BL_SLOTS = 4;
  localparam int CFG_INDEX_W = 3;

  // request codes
  localparam logic [1:0] FUNC_CREATE = 2'd0;
  localparam logic [1:0] FUNC_QUERY  = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;
  localparam logic [1:0] FUNC_CLEAR  = 2'd3;

  // result codes
  localparam logic [1:0] EV_CREATED  = 2'd0;
  localparam logic [1:0] EV_REJECTED = 2'd1;
  localparam logic [1:0] EV_REMOVED  = 2'd2;
  localparam logic [1:0] EV_QUERY    = 2'd3;

  // reject causes
  localparam logic [1:0] CAUSE_BLACK = 2'd0;
  localparam logic [1:0] CAUSE_DUP   = 2'd1;
  localparam logic [1:0] CAUSE_FULL  = 2'd2;
  localparam logic [1:0] CAUSE_NONE  = 2'd0;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BL_COUNT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BL_KEY_0 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BL_KEY_1 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BL_KEY_2 = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_BL_KEY_3 = 3'd5;

  // reset values
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd60;

endpackage

`default_nettype wire

FILE: hdl/session_table_with_aging_top.sv
`default_nettype none

// Session table with aging. A request is taken when start is high and busy is
// low; the block then stays busy for the sweep, which reads one entry per cycle
// from the key and start-tick memory (one read and one write port), and for
// the S_FINISH state that follows it. Create and query give
// one word at the end of the sweep; tick and clear give one removed word per
// session dropped, at most one per cycle, and none when nothing is dropped.
// Every word shows on the result ports for one cycle with strobe high and
// the receiver cannot hold it off; last marks the final word of a request.
// Valid bits sit in flip-flops, so no clearing pass follows reset.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must do so only while idle (not enforced).
module session_table_with_aging_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    func,
  input  wire logic [sta_pkg::KEY_W-1:0]     subscriber_key,
  input  wire logic                          cfg_we,
  input  wire logic [sta_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [sta_pkg::KEY_W-1:0]     cfg_data,
  output logic                               strobe,
  output logic [1:0]                         event_res,
  output logic [1:0]                         cause,
  output logic [sta_pkg::KEY_W-1:0]          record_key,
  output logic                               present,
  output logic                               last
);

  import sta_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_FINISH
  } state_t;

  state_t state;

  // configuration registers
  logic [TIMEOUT_W-1:0]  timeout_seconds;
  logic [BL_COUNT_W-1:0] blacklist_count;
  logic [KEY_W-1:0]      blacklist_key [BL_SLOTS];

  // table state
  logic [TABLE_DEPTH-1:0] valid;
  logic [KEY_W-1:0]       mem_key  [TABLE_DEPTH];
  logic [TICK_W-1:0]      mem_tick [TABLE_DEPTH];
  logic [TICK_W-1:0]      tick_counter;

  // request context
  logic [1:0]       func_r;
  logic [KEY_W-1:0] key_r;
  logic             barred;
  logic             found;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  // sweep pipeline
  logic [CNT_W-1:0]  cnt;
  logic              rd_vld;
  logic [IDX_W-1:0]  rd_idx;
  logic [KEY_W-1:0]  rd_key;
  logic [TICK_W-1:0] rd_tick;

  // removal held back one step so that last can be set
  logic             pend_valid;
  logic [KEY_W-1:0] pend_key;

  logic              accept;
  logic              barred_next;
  logic              entry_hit;
  logic [TICK_W-1:0] age;
  logic              drop;
  logic              create_ok;

  assign accept = start && !busy;
  assign busy = (state != S_IDLE);

  // blacklist check on the incoming key
  always_comb begin
    barred_next = 1'b0;
    for (int i = 0; i < BL_SLOTS; i++) begin
      if ((BL_COUNT_W'(i) < blacklist_count) && (blacklist_key[i] == subscriber_key)) begin
        barred_next = 1'b1;
      end
    end
  end

  // per-entry decisions on the word read back from memory
  always_comb begin
    entry_hit = rd_vld && valid[rd_idx];
    age = tick_counter - rd_tick;
    drop = 1'b0;
    case (func_r)
      FUNC_TICK:  drop = entry_hit && (age >= TICK_W'(timeout_seconds));
      FUNC_CLEAR: drop = entry_hit;
      default:    drop = 1'b0;
    endcase
  end

  assign create_ok = (state == S_FINISH) && (func_r == FUNC_CREATE) && !barred &&
                     !found && free_found;

  // key and start-tick memory, one read and one write port
  always_ff @(posedge clk) begin
    rd_key  <= mem_key[cnt[IDX_W-1:0]];
    rd_tick <= mem_tick[cnt[IDX_W-1:0]];
    if (create_ok) begin
      mem_key[free_idx]  <= key_r;
      mem_tick[free_idx] <= tick_counter;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_seconds <= TIMEOUT_RESET;
      blacklist_count <= '0;
      for (int i = 0; i < BL_SLOTS; i++) begin
        blacklist_key[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIMEOUT:  timeout_seconds <= cfg_data[TIMEOUT_W-1:0];
        REG_BL_COUNT: blacklist_count <= cfg_data[BL_COUNT_W-1:0];
        REG_BL_KEY_0: blacklist_key[0] <= cfg_data;
        REG_BL_KEY_1: blacklist_key[1] <= cfg_data;
        REG_BL_KEY_2: blacklist_key[2] <= cfg_data;
        REG_BL_KEY_3: blacklist_key[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer, table control and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      valid        <= '0;
      tick_counter <= '0;
      cnt          <= '0;
      rd_vld       <= 1'b0;
      pend_valid   <= 1'b0;
      strobe       <= 1'b0;
      last         <= 1'b0;
      found        <= 1'b0;
      free_found   <= 1'b0;
      barred       <= 1'b0;
      func_r       <= FUNC_CREATE;
    end else begin
      strobe <= 1'b0;
      last   <= 1'b0;
      case (state)
        S_IDLE: begin
          cnt    <= '0;
          rd_vld <= 1'b0;
          if (accept) begin
            func_r     <= func;
            key_r      <= subscriber_key;
            barred     <= barred_next;
            found      <= 1'b0;
            free_found <= 1'b0;
            pend_valid <= 1'b0;
            if (func == FUNC_TICK) begin
              tick_counter <= tick_counter + TICK_W'(1);
            end
            state <= S_SWEEP;
          end
        end

        S_SWEEP: begin
          // issue the next address
          if (cnt < CNT_W'(TABLE_DEPTH)) begin
            rd_vld <= 1'b1;
            rd_idx <= cnt[IDX_W-1:0];
            cnt    <= cnt + CNT_W'(1);
          end else begin
            rd_vld <= 1'b0;
          end
          // look at the entry read last cycle
          if (rd_vld) begin
            if (entry_hit && (rd_key == key_r)) begin
              found <= 1'b1;
            end
            if (!valid[rd_idx] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= rd_idx;
            end
            if (drop) begin
              valid[rd_idx] <= 1'b0;
              pend_valid    <= 1'b1;
              pend_key      <= rd_key;
              if (pend_valid) begin
                strobe     <= 1'b1;
                event_res  <= EV_REMOVED;
                cause      <= CAUSE_NONE;
                record_key <= pend_key;
                present    <= 1'b0;
              end
            end
            if (rd_idx == IDX_W'(TABLE_DEPTH - 1)) begin
              state <= S_FINISH;
            end
          end
        end

        S_FINISH: begin
          state      <= S_IDLE;
          record_key <= key_r;
          cause      <= CAUSE_NONE;
          present    <= 1'b0;
          case (func_r)
            FUNC_CREATE: begin
              strobe <= 1'b1;
              last   <= 1'b1;
              if (barred) begin
                event_res <= EV_REJECTED;
                cause     <= CAUSE_BLACK;
              end else if (found) begin
                event_res <= EV_REJECTED;
                cause     <= CAUSE_DUP;
              end else if (!free_found) begin
                event_res <= EV_REJECTED;
                cause     <= CAUSE_FULL;
              end else begin
                event_res       <= EV_CREATED;
                valid[free_idx] <= 1'b1;
              end
            end
            FUNC_QUERY: begin
              strobe    <= 1'b1;
              last      <= 1'b1;
              event_res <= EV_QUERY;
              present   <= found;
            end
            default: begin
              // flush the held removal as the final word
              event_res  <= EV_REMOVED;
              record_key <= pend_key;
              if (pend_valid) begin
                strobe <= 1'b1;
                last   <= 1'b1;
              end
              pend_valid <= 1'b0;
            end
          endcase
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `include "session_table_with_aging_top_assert.svh"

  `STA_ASSERT_NOW(a_last_ends_request, strobe && last, !busy, "final word while still busy")
  `STA_ASSERT_NOW(a_word_in_request, strobe && !last, busy, "non-final word outside a request")
  `STA_ASSERT_NEXT(a_start_takes, start && !busy, busy, "accepted request did not start")
  `STA_ASSERT_NOW(a_no_drop_outside, state == S_IDLE, !rd_vld, "read pending while idle")

endmodule

`default_nettype wire
